### src/ppmd_pkg.sv
// Package for the PPM frame decoder: sizes, reset values, codes and the
// command word passed from the front end to the execution back end.
// Depends on nothing; every other file imports it.
`default_nettype none
package ppmd_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int SLOT_W       = $clog2(NUM_CHANNELS + 1);
  localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  localparam int KIND_W  = 2;
  localparam int TIME_W  = 32;
  localparam int SEL_W   = 8;
  localparam int VALUE_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int Q_DEPTH  = 2;
  localparam int QPTR_W   = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCOUNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [KIND_W-1:0] KIND_CAPTURE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_POLL    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNUSED  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_SYNC_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_WIDTH      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH      = 2'd2;

  localparam logic [CFG_DATA_W-1:0] SYNC_THRESHOLD_RESET = 16'd3000;
  localparam logic [CFG_DATA_W-1:0] MIN_WIDTH_RESET      = 16'd800;
  localparam logic [CFG_DATA_W-1:0] MAX_WIDTH_RESET      = 16'd2200;
  localparam logic [VALUE_W-1:0]    DEFAULT_CHANNEL_VALUE = 16'd1500;

  typedef enum logic [1:0] {
    OP_CAPTURE,
    OP_READ,
    OP_POLL,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [TIME_W-1:0]   capture_time;
    logic                sel_in_range;
    logic [CH_IDX_W-1:0] sel_idx;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage
`default_nettype wire

### src/ppmd_if.sv
// Handshake channels of the PPM frame decoder: input items, result items and
// configuration writes. Each carries valid, ready and its payload.
// Depends on ppmd_pkg.
`default_nettype none
interface ppmd_item_if import ppmd_pkg::*;;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [TIME_W-1:0] capture_time;
  logic [SEL_W-1:0]  channel_select;
  modport source (output valid, kind, capture_time, channel_select, input ready);
  modport sink   (input valid, kind, capture_time, channel_select, output ready);
endinterface

interface ppmd_result_if import ppmd_pkg::*;;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] channel_value;
  logic               frame_ready;
  logic               sync_seen;
  modport source (output valid, channel_value, frame_ready, sync_seen, input ready);
  modport sink   (input valid, channel_value, frame_ready, sync_seen, output ready);
endinterface

interface ppmd_cfg_if import ppmd_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### src/ppmd_front.sv
// Front end: accepts input words, decodes the kind and range-checks the
// channel number, and hands a command word to the queue. Uses ppmd_pkg.
`default_nettype none
module ppmd_front import ppmd_pkg::*; (
  ppmd_item_if.sink item,
  input  qstat_t    qstat,
  output logic      push,
  output cmd_t      cmd
);

  assign item.ready = !qstat.full;
  assign push       = item.valid && !qstat.full;

  always_comb begin
    cmd.capture_time = item.capture_time;
    cmd.sel_in_range = item.channel_select < SEL_W'(NUM_CHANNELS);
    cmd.sel_idx      = item.channel_select[CH_IDX_W-1:0];
    unique case (item.kind)
      KIND_CAPTURE: cmd.op = OP_CAPTURE;
      KIND_READ:    cmd.op = OP_READ;
      KIND_POLL:    cmd.op = OP_POLL;
      KIND_UNUSED:  cmd.op = OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

### src/ppmd_queue.sv
// Short command queue between the front end and the back end, so that
// either side can stall alone. Uses ppmd_pkg.
`default_nettype none
module ppmd_queue import ppmd_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  cmd_t   push_cmd,
  input  logic   pop,
  output cmd_t   head,
  output qstat_t qstat
);

  cmd_t                mem [Q_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCOUNT_W-1:0] count;

  logic do_push;
  logic do_pop;

  assign qstat.full  = count == QCOUNT_W'(Q_DEPTH);
  assign qstat.empty = count == '0;
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head        = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCOUNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCOUNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

### src/ppmd_back.sv
// Back end: holds the configuration registers and decoder state, carries out
// one command per cycle while the result side is not stalled, and registers the result word. Uses ppmd_pkg.
`default_nettype none
module ppmd_back import ppmd_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  ppmd_cfg_if.sink      cfg,
  ppmd_result_if.source result,
  input  qstat_t qstat,
  input  cmd_t   head,
  output logic   pop
);

  logic [CFG_DATA_W-1:0] sync_threshold_us;
  logic [CFG_DATA_W-1:0] min_width_us;
  logic [CFG_DATA_W-1:0] max_width_us;

  logic [TIME_W-1:0]  last_edge_time;
  logic [SLOT_W-1:0]  slot_index;
  logic [VALUE_W-1:0] channel_store [NUM_CHANNELS];
  logic               frame_flag;

  logic               out_valid;
  logic [VALUE_W-1:0] out_value;
  logic               out_ready_flag;
  logic               out_sync;

  logic [TIME_W-1:0] width;
  logic              is_sync;
  logic              in_window;
  logic              slot_free;
  logic [SLOT_W-1:0] slot_index_next;

  assign cfg.ready            = 1'b1;
  assign result.valid         = out_valid;
  assign result.channel_value = out_value;
  assign result.frame_ready   = out_ready_flag;
  assign result.sync_seen     = out_sync;

  assign pop = !qstat.empty && (!out_valid || result.ready);

  assign width     = head.capture_time - last_edge_time;
  assign is_sync   = width > TIME_W'(sync_threshold_us);
  assign in_window = (width >= TIME_W'(min_width_us)) && (width <= TIME_W'(max_width_us));
  assign slot_free = slot_index < SLOT_W'(NUM_CHANNELS);
  assign slot_index_next = slot_free ? slot_index + SLOT_W'(1) : slot_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_threshold_us <= SYNC_THRESHOLD_RESET;
      min_width_us      <= MIN_WIDTH_RESET;
      max_width_us      <= MAX_WIDTH_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_SYNC_THRESHOLD: sync_threshold_us <= cfg.data;
        REG_MIN_WIDTH:      min_width_us      <= cfg.data;
        REG_MAX_WIDTH:      max_width_us      <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_edge_time <= '0;
      slot_index     <= '0;
      frame_flag     <= 1'b0;
      out_valid      <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        channel_store[i] <= '0;
      end
    end else begin
      if (pop) begin
        out_valid      <= 1'b1;
        out_value      <= '0;
        out_ready_flag <= 1'b0;
        out_sync       <= 1'b0;
        unique case (head.op)
          OP_CAPTURE: begin
            last_edge_time <= head.capture_time;
            if (is_sync) begin
              slot_index <= '0;
              out_sync   <= 1'b1;
            end else begin
              if (slot_free && in_window) begin
                channel_store[slot_index[CH_IDX_W-1:0]] <= width[VALUE_W-1:0];
              end
              slot_index <= slot_index_next;
              if (slot_index_next >= SLOT_W'(NUM_CHANNELS)) begin
                frame_flag <= 1'b1;
              end
            end
          end
          OP_READ: begin
            out_value <= head.sel_in_range ? channel_store[head.sel_idx]
                                           : DEFAULT_CHANNEL_VALUE;
          end
          OP_POLL: begin
            out_ready_flag <= frame_flag;
            frame_flag     <= 1'b0;
          end
          OP_NONE: ;
        endcase
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

### src/ppm_frame_decoder.sv
// Top level of the PPM frame decoder: front end, command queue and back end.
// Depends on ppmd_pkg, the channel interfaces and the three submodules.
//
//   Channel   Role    Payload                                   Words
//   item      sink    kind, capture_time, channel_select        one per cycle while queue not full
//   result    source  channel_value, frame_ready, sync_seen     one per item
//   cfg       sink    index, data                               always ready
//
// One item is taken per cycle while the queue is not full. Its command is written
// into the queue, waits there until the result register is free or being read,
// and is then executed into the result register.
// While the result side stalls, the two-entry queue and the result register
// hold up to three items; the input is ready again once the queue is not full.
// Synchronous reset restores the register defaults and clears the queue, the decoder state and the result valid.
`default_nettype none
module ppm_frame_decoder import ppmd_pkg::*; (
  input  logic clk,
  input  logic rst,
  ppmd_item_if.sink     item,
  ppmd_result_if.source result,
  ppmd_cfg_if.sink      cfg
);

  qstat_t qstat;
  cmd_t   push_cmd;
  cmd_t   head;
  logic   push;
  logic   pop;

  ppmd_front u_front (
    .item  (item),
    .qstat (qstat),
    .push  (push),
    .cmd   (push_cmd)
  );

  ppmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  ppmd_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .result (result),
    .qstat  (qstat),
    .head   (head),
    .pop    (pop)
  );

  a_queue_status: assert property (@(posedge clk) disable iff (rst)
    !(qstat.full && qstat.empty))
    else $error("queue reports full and empty together");

  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |=> !qstat.empty)
    else $error("accepted word did not reach the queue");

  a_pop_gives_result: assert property (@(posedge clk) disable iff (rst)
    pop |=> result.valid)
    else $error("executed command produced no result word");

  a_single_flag: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.sync_seen && result.frame_ready))
    else $error("sync and frame flags raised in one result word");

endmodule
`default_nettype wire

### tb/tb_ppm_frame_decoder.sv
// Self-checking testbench for the PPM frame decoder: drives capture, read, poll and
// unused words and checks every result word against a local decoding model.
// Depends on ppmd_pkg, the channel interfaces and ppm_frame_decoder.
module tb_ppm_frame_decoder;
  import ppmd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TIME_W-1:0] capture_time;
    logic [SEL_W-1:0]  channel_select;
  } ppm_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] channel_value;
    logic               frame_ready;
    logic               sync_seen;
  } ppm_word_t;

  logic clk = 1'b0;
  logic rst;

  ppmd_item_if   item_ch ();
  ppmd_result_if res_ch ();
  ppmd_cfg_if    cfg_ch ();

  ppm_frame_decoder u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Decoder state as seen from outside, advanced on every accepted word.
  logic [CFG_DATA_W-1:0] cfg_sync;
  logic [CFG_DATA_W-1:0] cfg_min;
  logic [CFG_DATA_W-1:0] cfg_max;
  logic [TIME_W-1:0]     last_edge;
  logic [SLOT_W-1:0]     slot_idx;
  logic [VALUE_W-1:0]    ch_store [NUM_CHANNELS];
  logic                  frame_flag;

  ppm_item_t   item_backlog [$];
  ppm_word_t   decoded_results [$];
  logic [TIME_W-1:0] gen_time;
  int unsigned fail_count;
  int unsigned idle_pct;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned hold_left;
  int unsigned cycle_count;
  logic        hold_req;
  logic        item_taken;

  function automatic ppm_word_t decode_item(ppm_item_t it);
    ppm_word_t         w;
    logic [TIME_W-1:0] interval;
    w = '0;
    case (it.kind)
      KIND_CAPTURE: begin
        interval  = it.capture_time - last_edge;
        last_edge = it.capture_time;
        if (interval > cfg_sync) begin
          slot_idx    = '0;
          w.sync_seen = 1'b1;
        end else begin
          if (slot_idx < NUM_CHANNELS) begin
            if (interval >= cfg_min && interval <= cfg_max) begin
              ch_store[slot_idx] = interval[VALUE_W-1:0];
            end
            slot_idx = slot_idx + 1'b1;
          end
          if (slot_idx >= NUM_CHANNELS) begin
            frame_flag = 1'b1;
          end
        end
      end
      KIND_READ: begin
        if (it.channel_select < NUM_CHANNELS) begin
          w.channel_value = ch_store[it.channel_select];
        end else begin
          w.channel_value = DEFAULT_CHANNEL_VALUE;
        end
      end
      KIND_POLL: begin
        w.frame_ready = frame_flag;
        frame_flag    = 1'b0;
      end
      default: begin
      end
    endcase
    return w;
  endfunction

  task automatic flag_error(string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("ERROR at %0t: %s", $realtime, msg);
    end
  endtask

  // Driver: words change at the falling edge and are taken at the rising edge.
  always @(posedge clk) begin : accept_items
    ppm_item_t it;
    if (!rst && item_ch.valid && item_ch.ready) begin
      it = '{kind: item_ch.kind, capture_time: item_ch.capture_time,
             channel_select: item_ch.channel_select};
      decoded_results.push_back(decode_item(it));
      item_taken = 1'b1;
    end
  end

  always @(negedge clk) begin : drive_items
    ppm_item_t it;
    if (!(item_ch.valid && !item_taken)) begin
      item_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        item_ch.valid <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
        gap_left = $urandom_range(0, 6);
        item_ch.valid <= 1'b0;
      end else if (item_backlog.size() != 0) begin
        it = item_backlog.pop_front();
        item_ch.valid          <= 1'b1;
        item_ch.kind           <= it.kind;
        item_ch.capture_time   <= it.capture_time;
        item_ch.channel_select <= it.channel_select;
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: compares each result word with the oldest decoded one.
  always @(posedge clk) begin : check_results
    ppm_word_t w;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (decoded_results.size() == 0) begin
        flag_error($sformatf("result word with none pending: value %0d ready %0b sync %0b",
                             res_ch.channel_value, res_ch.frame_ready, res_ch.sync_seen));
      end else begin
        w = decoded_results.pop_front();
        if (res_ch.channel_value !== w.channel_value) begin
          flag_error($sformatf("channel_value expected %0d, got %0d",
                               w.channel_value, res_ch.channel_value));
        end
        if (res_ch.frame_ready !== w.frame_ready) begin
          flag_error($sformatf("frame_ready expected %0b, got %0b",
                               w.frame_ready, res_ch.frame_ready));
        end
        if (res_ch.sync_seen !== w.sync_seen) begin
          flag_error($sformatf("sync_seen expected %0b, got %0b",
                               w.sync_seen, res_ch.sync_seen));
        end
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      res_ch.ready <= 1'b0;
    end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      stall_left = $urandom_range(0, 6);
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= (hold_left == 0);
    end
  end

  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      hold_left <= 80;
      hold_req = 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_ppm_frame_decoder failed");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_SYNC_THRESHOLD: cfg_sync = val;
      REG_MIN_WIDTH:      cfg_min  = val;
      REG_MAX_WIDTH:      cfg_max  = val;
      default: begin
      end
    endcase
  endtask

  task automatic set_window(logic [15:0] thr, logic [15:0] lo, logic [15:0] hi);
    write_reg(REG_SYNC_THRESHOLD, thr);
    write_reg(REG_MIN_WIDTH, lo);
    write_reg(REG_MAX_WIDTH, hi);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic push_item(logic [KIND_W-1:0] k, logic [TIME_W-1:0] t, logic [SEL_W-1:0] s);
    item_backlog.push_back('{kind: k, capture_time: t, channel_select: s});
  endtask

  task automatic push_edge_at(logic [TIME_W-1:0] t);
    gen_time = t;
    push_item(KIND_CAPTURE, t, SEL_W'($urandom_range(0, 255)));
  endtask

  task automatic push_edge(logic [TIME_W-1:0] interval);
    push_edge_at(gen_time + interval);
  endtask

  task automatic push_read(logic [SEL_W-1:0] s);
    push_item(KIND_READ, $urandom(), s);
  endtask

  task automatic push_poll();
    push_item(KIND_POLL, $urandom(), SEL_W'($urandom_range(0, 255)));
  endtask

  task automatic push_noise();
    case ($urandom_range(0, 2))
      0: push_item(KIND_UNUSED, $urandom(), SEL_W'($urandom_range(0, 255)));
      1: push_edge_at($urandom());
      default: push_read(SEL_W'($urandom_range(0, 255)));
    endcase
  endtask

  function automatic logic [TIME_W-1:0] channel_width();
    int unsigned lo;
    int unsigned hi;
    lo = (cfg_min > 60) ? cfg_min - 60 : 0;
    hi = cfg_max + 60;
    case ($urandom_range(0, 11))
      0: return TIME_W'(cfg_min);
      1: return TIME_W'(cfg_max);
      2: return TIME_W'(cfg_sync);
      3: return cfg_sync + 1;
      4: return '0;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  task automatic push_frame();
    int unsigned n;
    push_edge(cfg_sync + $urandom_range(1, 6000));
    if ($urandom_range(0, 9) < 6) begin
      n = NUM_CHANNELS + $urandom_range(0, 1);
    end else begin
      n = $urandom_range(0, NUM_CHANNELS + 2);
    end
    repeat (n) begin
      push_edge(channel_width());
      if ($urandom_range(0, 15) == 0) begin
        push_read(SEL_W'($urandom_range(0, NUM_CHANNELS + 1)));
      end
    end
    repeat ($urandom_range(0, 3)) push_read(SEL_W'($urandom_range(0, NUM_CHANNELS + 1)));
    if ($urandom_range(0, 1) == 1) begin
      push_poll();
    end
    if ($urandom_range(0, 9) == 0) begin
      push_noise();
    end
  endtask

  task automatic fill_frames(int unsigned count);
    while (item_backlog.size() < count) push_frame();
  endtask

  task automatic settle();
    int unsigned waited;
    waited = 0;
    while (item_backlog.size() != 0 || item_ch.valid) @(posedge clk);
    while (decoded_results.size() != 0 && waited < 500) begin
      @(negedge clk);
      waited++;
    end
    if (decoded_results.size() != 0) begin
      flag_error($sformatf("%0d result words never arrived", decoded_results.size()));
      decoded_results.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  initial begin
    rst                    = 1'b1;
    item_ch.valid          = 1'b0;
    item_ch.kind           = KIND_CAPTURE;
    item_ch.capture_time   = '0;
    item_ch.channel_select = '0;
    res_ch.ready           = 1'b0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.index           = REG_SYNC_THRESHOLD;
    cfg_ch.data            = '0;
    cfg_sync   = SYNC_THRESHOLD_RESET;
    cfg_min    = MIN_WIDTH_RESET;
    cfg_max    = MAX_WIDTH_RESET;
    last_edge  = '0;
    slot_idx   = '0;
    frame_flag = 1'b0;
    for (int i = 0; i < NUM_CHANNELS; i++) ch_store[i] = '0;
    gen_time    = '0;
    fail_count  = 0;
    idle_pct    = 15;
    gap_left    = 0;
    stall_left  = 0;
    hold_left   = 0;
    hold_req    = 1'b0;
    item_taken  = 1'b0;
    cycle_count = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reads and a poll straight after reset, then a full frame with window edges.
    push_read(8'h00);
    push_read(SEL_W'(NUM_CHANNELS));
    push_read(8'hFF);
    push_poll();
    push_item(KIND_UNUSED, 32'hFFFF_FFFF, 8'hFF);
    push_edge(1500);
    push_edge(5000);
    push_edge(800);
    push_edge(2200);
    push_edge(799);
    push_edge(2201);
    push_edge(1000);
    push_edge(1500);
    push_edge(1700);
    push_edge(1200);
    push_edge(1100);
    push_poll();
    push_poll();
    push_read(8'h00);
    push_read(8'h02);
    push_read(SEL_W'(NUM_CHANNELS - 1));
    push_edge_at(32'hFFFF_FE00);
    push_edge_at(32'h0000_01E8);
    push_edge_at(32'hFFFF_FFFF);
    push_edge_at(32'h0000_0000);
    push_read(8'h00);
    settle();

    idle_pct = 40;
    fill_frames(300);
    repeat (20) @(posedge clk);
    hold_req = 1'b1;
    settle();

    set_window(16'hFFFF, 16'h0000, 16'hFFFF);
    idle_pct = 15;
    fill_frames(300);
    settle();

    set_window(16'h0000, 16'h0000, 16'h0000);
    idle_pct = 40;
    fill_frames(260);
    settle();

    set_window(16'd3000, 16'd2000, 16'd1000);
    idle_pct = 0;
    fill_frames(260);
    settle();

    set_window(16'($urandom_range(2000, 8000)), 16'($urandom_range(0, 3000)),
               16'($urandom_range(0, 3000)));
    idle_pct = 15;
    fill_frames(320);
    settle();

    set_window(SYNC_THRESHOLD_RESET, MIN_WIDTH_RESET, MAX_WIDTH_RESET);
    idle_pct = 0;
    fill_frames(320);
    settle();

    if (fail_count == 0) begin
      $display("tb_ppm_frame_decoder passed");
    end else begin
      $display("tb_ppm_frame_decoder failed");
    end
    $finish;
  end

endmodule
